[sv/gse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_pkg - shared types and constants for the gray/Sobel edge stream core
// Luma weights, saturation level, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package gse_pkg;

   localparam logic [15:0] W_BLUE  = 16'd4732;
   localparam logic [15:0] W_GREEN = 16'd46871;
   localparam logic [15:0] W_RED   = 16'd13933;

   localparam logic [7:0]  SAT_LEVEL = 8'd255;

   localparam int          QUEUE_DEPTH = 4;
   localparam int          QPTR_W      = 2;

   localparam logic [10:0] ROW_LAST = 11'd2047;

   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [11:0] HEIGHT_RESET = 12'd480;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic        edge_valid;
      logic        frame_end;
      logic [10:0] centre_col;
      logic [10:0] centre_row;
   } meta_type;

endpackage

[sv/gse_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_ram - generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/gse_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_front - pixel intake, raster position tracking and classification
// Holds the frame size registers and the column/row counters, and tags
// each word with its window status, centre position and frame end.
// ----------------------------------------------------------------------------
module gse_front #(
   parameter int MAX_LINE_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [0:0]                        csr_index,
   input  logic [11:0]                       csr_wdata,
   input  logic                              accept,
   input  logic [23:0]                       pixel,
   output gse_pkg::meta_type                 meta,
   output logic [$clog2(MAX_LINE_WIDTH)-1:0] col
);

   import gse_pkg::*;

   localparam int CW = $clog2(MAX_LINE_WIDTH);
   localparam int XW = ((CW > 12) ? CW : 12) + 1;
   localparam int PW = (CW > 11) ? CW : 11;
   localparam logic [CW-1:0] COL_LAST = CW'(MAX_LINE_WIDTH - 1);

   logic [11:0]   width_ff, width_in;
   logic [11:0]   height_ff, height_in;
   logic [CW-1:0] col_ff, col_in;
   logic [10:0]   row_ff, row_in;

   logic          last_col, last_row, valid;
   logic [PW-1:0] centre_col_full;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_comb begin
      last_col = (XW'(col_ff) + XW'(1) >= XW'(width_ff)) || (col_ff == COL_LAST);
      last_row = (({1'b0, row_ff} + 12'd1) >= height_ff) || (row_ff == ROW_LAST);
      valid    = (row_ff >= 11'd2) && (XW'(col_ff) >= XW'(2));
      centre_col_full = PW'(col_ff) - PW'(1);

      meta.blue       = pixel[7:0];
      meta.green      = pixel[15:8];
      meta.red        = pixel[23:16];
      meta.edge_valid = valid;
      meta.frame_end  = last_col && last_row;
      meta.centre_col = valid ? centre_col_full[10:0] : 11'd0;
      meta.centre_row = valid ? (row_ff - 11'd1) : 11'd0;
      col             = col_ff;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? 11'd0 : (row_ff + 11'd1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

[sv/gse_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_queue - short word queue between intake and processing pipeline
// Flop-based circular buffer; the head is visible without a pop.
// ----------------------------------------------------------------------------
module gse_queue #(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             head_valid,
   output logic             full
);

   import gse_pkg::*;

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data  = slot_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));

endmodule

[sv/gse_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_back - luma, line store and Sobel pipeline
// Four stages: weighted products, luma sum with line store read, window
// shift with gradients, and magnitude into the output register.
// ----------------------------------------------------------------------------
module gse_back #(
   parameter int MAX_LINE_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  gse_pkg::meta_type                 head_meta,
   input  logic [$clog2(MAX_LINE_WIDTH)-1:0] head_col,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   import gse_pkg::*;

   localparam int CW = $clog2(MAX_LINE_WIDTH);

   logic advance;

   // products stage
   logic          b_valid_ff;
   meta_type      b_meta_ff;
   logic [CW-1:0] b_col_ff;
   logic [20:0]   b_prod_blue_ff;
   logic [23:0]   b_prod_green_ff;
   logic [21:0]   b_prod_red_ff;
   logic          b_fwd_ff;
   logic [7:0]    b_fwd_top_ff, b_fwd_mid_ff;

   // luma stage
   logic          c_valid_ff;
   meta_type      c_meta_ff;
   logic [CW-1:0] c_col_ff;
   logic [7:0]    c_luma_ff, c_top_ff, c_mid_ff;
   logic [23:0]   luma_sum;
   logic [7:0]    top_in, mid_in;

   // gradient stage
   logic              d_valid_ff;
   meta_type          d_meta_ff;
   logic [7:0]        d_luma_ff;
   logic signed [11:0] d_gx_ff, d_gy_ff;
   logic signed [11:0] gx_in, gy_in;
   logic [7:0]        win_ff [6];

   // output stage
   logic        out_valid_ff;
   meta_type    out_meta_ff;
   logic [7:0]  out_luma_ff, out_mag_ff;
   logic [11:0] abs_gx, abs_gy;
   logic [12:0] mag_sum;
   logic [7:0]  mag_in;

   logic [7:0] upper_rd, middle_rd;

   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance && head_valid;

   gse_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (advance && c_valid_ff),
      .wr_addr (c_col_ff),
      .wr_data (c_mid_ff),
      .rd_en   (pop),
      .rd_addr (head_col),
      .rd_data (upper_rd)
   );

   gse_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (advance && c_valid_ff),
      .wr_addr (c_col_ff),
      .wr_data (c_luma_ff),
      .rd_en   (pop),
      .rd_addr (head_col),
      .rd_data (middle_rd)
   );

   always_comb begin
      luma_sum = 24'(b_prod_blue_ff) + b_prod_green_ff + 24'(b_prod_red_ff);

      // bypass line store writes that land after the read
      if (c_valid_ff && (c_col_ff == b_col_ff)) begin
         top_in = c_mid_ff;
         mid_in = c_luma_ff;
      end else if (b_fwd_ff) begin
         top_in = b_fwd_top_ff;
         mid_in = b_fwd_mid_ff;
      end else begin
         top_in = upper_rd;
         mid_in = middle_rd;
      end

      gx_in = ($signed({4'd0, c_top_ff}) + $signed({3'd0, c_mid_ff, 1'b0})
               + $signed({4'd0, c_luma_ff}))
            - ($signed({4'd0, win_ff[0]}) + $signed({3'd0, win_ff[1], 1'b0})
               + $signed({4'd0, win_ff[2]}));
      gy_in = ($signed({4'd0, win_ff[0]}) + $signed({3'd0, win_ff[3], 1'b0})
               + $signed({4'd0, c_top_ff}))
            - ($signed({4'd0, win_ff[2]}) + $signed({3'd0, win_ff[5], 1'b0})
               + $signed({4'd0, c_luma_ff}));

      abs_gx  = d_gx_ff[11] ? 12'(-d_gx_ff) : 12'(d_gx_ff);
      abs_gy  = d_gy_ff[11] ? 12'(-d_gy_ff) : 12'(d_gy_ff);
      mag_sum = 13'(abs_gx) + 13'(abs_gy);
      if (!d_meta_ff.edge_valid) begin
         mag_in = 8'd0;
      end else if (mag_sum > 13'(SAT_LEVEL)) begin
         mag_in = SAT_LEVEL;
      end else begin
         mag_in = mag_sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff   <= head_valid;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         out_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_meta_ff       <= head_meta;
         b_col_ff        <= head_col;
         b_prod_blue_ff  <= 21'(head_meta.blue) * 21'(W_BLUE);
         b_prod_green_ff <= 24'(head_meta.green) * 24'(W_GREEN);
         b_prod_red_ff   <= 22'(head_meta.red) * 22'(W_RED);
         b_fwd_ff        <= c_valid_ff && (c_col_ff == head_col);
         b_fwd_top_ff    <= c_mid_ff;
         b_fwd_mid_ff    <= c_luma_ff;

         c_meta_ff <= b_meta_ff;
         c_col_ff  <= b_col_ff;
         c_luma_ff <= luma_sum[23:16];
         c_top_ff  <= top_in;
         c_mid_ff  <= mid_in;

         d_meta_ff <= c_meta_ff;
         d_luma_ff <= c_luma_ff;
         d_gx_ff   <= gx_in;
         d_gy_ff   <= gy_in;

         out_meta_ff <= d_meta_ff;
         out_luma_ff <= d_luma_ff;
         out_mag_ff  <= mag_in;
      end
      if (advance && c_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= c_top_ff;
         win_ff[4] <= c_mid_ff;
         win_ff[5] <= c_luma_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_meta_ff.centre_row, out_meta_ff.centre_col,
                        out_mag_ff, out_luma_ff};
   assign rsp_tuser  = out_meta_ff.edge_valid;
   assign rsp_tlast  = out_meta_ff.frame_end;

endmodule

[sv/gray_sobel_edge_stream_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_sobel_edge_stream_core - RGB to luma with 3x3 Sobel edge magnitude
// Raster BGR pixels in, one word out per pixel: luma plus, once a full
// 3x3 window exists, the edge magnitude and the position of its centre.
//
// req_* carries one pixel per word. rsp_* returns one word per pixel in
// arrival order; tuser flags a valid edge and tlast marks the frame end.
// csr_* writes frame_width (index 0) and frame_height (index 1) at any
// edge where csr_we is high; write them only while the core is idle.
// Throughput: one pixel per clock while rsp_tready stays high. Each
// pixel passes the queue, product, luma/line read, gradient and output
// register stages before rsp_tvalid rises for it.
// Reset: frame size 640x480, counters zero, queue and pipeline empty;
// the line stores are not cleared and are first read a full line after
// they are written.
// Stall: a low rsp_tready with rsp_tvalid high freezes the pipeline; the four-word queue
// keeps taking pixels until it fills, then req_tready drops.
// ----------------------------------------------------------------------------
module gray_sobel_edge_stream_core #(
   parameter int MAX_LINE_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue[7:0], green[15:8], red[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // luma[7:0], edge_magnitude[15:8],
                                    // centre_col[26:16], centre_row[37:27]
   output logic        rsp_tuser,   // edge_valid[0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   import gse_pkg::*;

   localparam int CW = $clog2(MAX_LINE_WIDTH);
   localparam int QW = CW + $bits(meta_type);

   logic          accept, queue_full, head_valid, pop;
   meta_type      front_meta, head_meta;
   logic [CW-1:0] front_col, head_col;
   logic [QW-1:0] head_data;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   gse_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .pixel     (req_tdata),
      .meta      (front_meta),
      .col       (front_col)
   );

   gse_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  ({front_col, front_meta}),
      .pop        (pop),
      .head_data  (head_data),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   assign head_meta = meta_type'(head_data[$bits(meta_type)-1:0]);
   assign head_col  = head_data[QW-1:$bits(meta_type)];

   gse_back #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_meta  (head_meta),
      .head_col   (head_col),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
